// ===== rtl/sabb_pkg.sv =====
// shared types, constants and size table for the sprite attribute decoder
`timescale 1ns / 1ps
`default_nettype none

package sabb_pkg;

    localparam int SIZE_W  = 7;
    localparam int TILE_W  = 10;
    localparam int PRIO_W  = 2;
    localparam int PAL_W   = 4;
    localparam int MTX_W   = 5;
    localparam int FLAG_W  = 9;
    localparam int POS_W   = 16;
    localparam int EDGE_W  = 17;

    localparam int QUEUE_DEPTH = 2;

    // mode_flags bit positions
    localparam int FLAG_MOSAIC  = 2;
    localparam int FLAG_AFFINE  = 3;
    localparam int FLAG_FLIPX   = 4;
    localparam int FLAG_FLIPY   = 5;
    localparam int FLAG_DOUBLE  = 6;
    localparam int FLAG_DISABLE = 7;
    localparam int FLAG_EIGHT   = 8;

    // empty box values
    localparam logic signed [EDGE_W-1:0] BOX_EMPTY_MIN = 17'sd32767;
    localparam logic signed [EDGE_W-1:0] BOX_EMPTY_MAX = -17'sd32767;

    typedef enum logic [1:0] {
        SHAPE_SQUARE = 2'd0,
        SHAPE_WIDE   = 2'd1,
        SHAPE_TALL   = 2'd2,
        SHAPE_NONE   = 2'd3
    } shape_t;

    // decoded sprite entry passed from front to back
    typedef struct packed {
        logic [SIZE_W-1:0]        obj_width;
        logic [SIZE_W-1:0]        obj_height;
        logic [TILE_W-1:0]        tile_index;
        logic [PRIO_W-1:0]        draw_priority;
        logic [PAL_W-1:0]         palette_num;
        logic [MTX_W-1:0]         affine_index;
        logic [FLAG_W-1:0]        mode_flags;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [EDGE_W-1:0] edge_right;
        logic signed [EDGE_W-1:0] edge_bottom;
        logic                     last_entry;
    } dec_t;

    // base size per size code: 8, 16, 32, 64
    function automatic logic [SIZE_W-1:0] base_size(input logic [1:0] code);
        logic [SIZE_W-1:0] r;
        unique case (code)
            2'd0:    r = 7'd8;
            2'd1:    r = 7'd16;
            2'd2:    r = 7'd32;
            default: r = 7'd64;
        endcase
        return r;
    endfunction

    // long side of a non-square sprite: 16, 32, 32, 64
    function automatic logic [SIZE_W-1:0] long_size(input logic [1:0] code);
        logic [SIZE_W-1:0] r;
        unique case (code)
            2'd0:    r = 7'd16;
            2'd1:    r = 7'd32;
            2'd2:    r = 7'd32;
            default: r = 7'd64;
        endcase
        return r;
    endfunction

    // short side of a non-square sprite: 8, 8, 16, 32
    function automatic logic [SIZE_W-1:0] short_size(input logic [1:0] code);
        logic [SIZE_W-1:0] r;
        unique case (code)
            2'd0:    r = 7'd8;
            2'd1:    r = 7'd8;
            2'd2:    r = 7'd16;
            default: r = 7'd32;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sabb_front.sv =====
// front stage: accepts sprite entries, decodes attributes and edges
`timescale 1ns / 1ps
`default_nettype none

module sabb_front
    import sabb_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [15:0]             s_word0,
    input  wire logic [15:0]             s_word1,
    input  wire logic [15:0]             s_word2,
    input  wire logic signed [POS_W-1:0] s_pos_x,
    input  wire logic signed [POS_W-1:0] s_pos_y,
    input  wire logic                    s_last_entry,
    output logic                         push_valid,
    input  wire logic                    push_ready,
    output dec_t                         push_data
);

    logic   valid_reg;
    logic   valid_next;
    dec_t   data_reg;
    dec_t   dec;

    shape_t            shape;
    logic [1:0]        size_code;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic              affine;
    logic              bit9;

    always_comb begin
        shape     = shape_t'(s_word0[15:14]);
        size_code = s_word1[15:14];
        unique case (shape)
            SHAPE_SQUARE: begin
                w = base_size(size_code);
                h = base_size(size_code);
            end
            SHAPE_WIDE: begin
                w = long_size(size_code);
                h = short_size(size_code);
            end
            SHAPE_TALL: begin
                w = short_size(size_code);
                h = long_size(size_code);
            end
            default: begin
                // no table row: always 8x8
                w = 7'd8;
                h = 7'd8;
            end
        endcase

        affine = s_word0[8];
        bit9   = s_word0[9];

        dec.obj_width     = w;
        dec.obj_height    = h;
        dec.tile_index    = s_word2[9:0];
        dec.draw_priority = s_word2[11:10];
        dec.palette_num   = s_word2[15:12];
        dec.affine_index  = affine ? s_word1[13:9] : '0;

        dec.mode_flags               = '0;
        dec.mode_flags[1:0]          = s_word0[11:10];
        dec.mode_flags[FLAG_MOSAIC]  = s_word0[12];
        dec.mode_flags[FLAG_AFFINE]  = affine;
        dec.mode_flags[FLAG_FLIPX]   = !affine && s_word1[12];
        dec.mode_flags[FLAG_FLIPY]   = !affine && s_word1[13];
        dec.mode_flags[FLAG_DOUBLE]  = affine && bit9;
        dec.mode_flags[FLAG_DISABLE] = !affine && bit9;
        dec.mode_flags[FLAG_EIGHT]   = s_word0[13];

        dec.pos_x       = s_pos_x;
        dec.pos_y       = s_pos_y;
        dec.edge_right  = {s_pos_x[POS_W-1], s_pos_x} + {{(EDGE_W-SIZE_W){1'b0}}, w};
        dec.edge_bottom = {s_pos_y[POS_W-1], s_pos_y} + {{(EDGE_W-SIZE_W){1'b0}}, h};
        dec.last_entry  = s_last_entry;
    end

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= dec;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sabb_queue.sv =====
// short queue of decoded entries between front and back
`timescale 1ns / 1ps
`default_nettype none

module sabb_queue
    import sabb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire dec_t push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output dec_t      pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dec_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sabb_back.sv =====
// back stage: running bounding box and result register
`timescale 1ns / 1ps
`default_nettype none

module sabb_back
    import sabb_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    input  wire dec_t                pop_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [SIZE_W-1:0]        m_obj_width,
    output logic [SIZE_W-1:0]        m_obj_height,
    output logic [TILE_W-1:0]        m_tile_index,
    output logic [PRIO_W-1:0]        m_draw_priority,
    output logic [PAL_W-1:0]         m_palette_num,
    output logic [MTX_W-1:0]         m_affine_index,
    output logic [FLAG_W-1:0]        m_mode_flags,
    output logic signed [POS_W-1:0]  m_box_left,
    output logic signed [EDGE_W-1:0] m_box_right,
    output logic signed [POS_W-1:0]  m_box_top,
    output logic signed [EDGE_W-1:0] m_box_bottom,
    output logic                     m_cell_done
);

    logic                     out_valid_reg;
    logic                     out_valid_next;
    dec_t                     out_reg;
    logic signed [EDGE_W-1:0] box_l_reg, box_r_reg, box_t_reg, box_b_reg;

    logic signed [EDGE_W-1:0] acc_left_reg,   acc_left_next;
    logic signed [EDGE_W-1:0] acc_right_reg,  acc_right_next;
    logic signed [EDGE_W-1:0] acc_top_reg,    acc_top_next;
    logic signed [EDGE_W-1:0] acc_bottom_reg, acc_bottom_next;

    logic signed [EDGE_W-1:0] px;
    logic signed [EDGE_W-1:0] py;
    logic signed [EDGE_W-1:0] new_l, new_r, new_t, new_b;
    logic                     take;

    assign pop_ready = !out_valid_reg || m_ready;
    assign take      = pop_valid && pop_ready;

    always_comb begin
        px    = {pop_data.pos_x[POS_W-1], pop_data.pos_x};
        py    = {pop_data.pos_y[POS_W-1], pop_data.pos_y};
        new_l = (px < acc_left_reg) ? px : acc_left_reg;
        new_r = (pop_data.edge_right > acc_right_reg) ? pop_data.edge_right : acc_right_reg;
        new_t = (py < acc_top_reg) ? py : acc_top_reg;
        new_b = (pop_data.edge_bottom > acc_bottom_reg) ? pop_data.edge_bottom
                                                        : acc_bottom_reg;

        acc_left_next   = acc_left_reg;
        acc_right_next  = acc_right_reg;
        acc_top_next    = acc_top_reg;
        acc_bottom_next = acc_bottom_reg;
        if (take) begin
            // box goes back to empty once the cell is finished
            if (pop_data.last_entry) begin
                acc_left_next   = BOX_EMPTY_MIN;
                acc_right_next  = BOX_EMPTY_MAX;
                acc_top_next    = BOX_EMPTY_MIN;
                acc_bottom_next = BOX_EMPTY_MAX;
            end else begin
                acc_left_next   = new_l;
                acc_right_next  = new_r;
                acc_top_next    = new_t;
                acc_bottom_next = new_b;
            end
        end

        out_valid_next = out_valid_reg;
        if (pop_ready) begin
            out_valid_next = pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            acc_left_reg   <= BOX_EMPTY_MIN;
            acc_right_reg  <= BOX_EMPTY_MAX;
            acc_top_reg    <= BOX_EMPTY_MIN;
            acc_bottom_reg <= BOX_EMPTY_MAX;
        end else begin
            out_valid_reg  <= out_valid_next;
            acc_left_reg   <= acc_left_next;
            acc_right_reg  <= acc_right_next;
            acc_top_reg    <= acc_top_next;
            acc_bottom_reg <= acc_bottom_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg   <= pop_data;
            box_l_reg <= new_l;
            box_r_reg <= new_r;
            box_t_reg <= new_t;
            box_b_reg <= new_b;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_obj_width     = out_reg.obj_width;
    assign m_obj_height    = out_reg.obj_height;
    assign m_tile_index    = out_reg.tile_index;
    assign m_draw_priority = out_reg.draw_priority;
    assign m_palette_num   = out_reg.palette_num;
    assign m_affine_index  = out_reg.affine_index;
    assign m_mode_flags    = out_reg.mode_flags;
    // the box includes this entry, so left and top always fit 16 bits
    assign m_box_left      = box_l_reg[POS_W-1:0];
    assign m_box_right     = box_r_reg;
    assign m_box_top       = box_t_reg[POS_W-1:0];
    assign m_box_bottom    = box_b_reg;
    assign m_cell_done     = out_reg.last_entry;

endmodule

`default_nettype wire

// ===== rtl/sprite_attr_decode_bbox_top.sv =====
// sprite attribute decoder with running cell bounding box
// path: an input beat reaches the result beat through the decode register, the queue and the result register
// throughput: one beat per cycle while m_ready holds high; the queue lets decode and box update stall on their own
// the box min/max update is a single 17-bit compare-select per edge in the back stage
// reset: synchronous active-low aresetn empties the queue, drops valids and clears the box
`timescale 1ns / 1ps
`default_nettype none

module sprite_attr_decode_bbox_top
    import sabb_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [15:0]             s_word0,
    input  wire logic [15:0]             s_word1,
    input  wire logic [15:0]             s_word2,
    input  wire logic signed [POS_W-1:0] s_pos_x,
    input  wire logic signed [POS_W-1:0] s_pos_y,
    input  wire logic                    s_last_entry,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [SIZE_W-1:0]            m_obj_width,
    output logic [SIZE_W-1:0]            m_obj_height,
    output logic [TILE_W-1:0]            m_tile_index,
    output logic [PRIO_W-1:0]            m_draw_priority,
    output logic [PAL_W-1:0]             m_palette_num,
    output logic [MTX_W-1:0]             m_affine_index,
    output logic [FLAG_W-1:0]            m_mode_flags,
    output logic signed [POS_W-1:0]      m_box_left,
    output logic signed [EDGE_W-1:0]     m_box_right,
    output logic signed [POS_W-1:0]      m_box_top,
    output logic signed [EDGE_W-1:0]     m_box_bottom,
    output logic                         m_cell_done
);

    logic push_valid, push_ready;
    dec_t push_data;
    logic pop_valid, pop_ready;
    dec_t pop_data;

    sabb_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_word0      (s_word0),
        .s_word1      (s_word1),
        .s_word2      (s_word2),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_last_entry (s_last_entry),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    sabb_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sabb_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_data        (pop_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_obj_width     (m_obj_width),
        .m_obj_height    (m_obj_height),
        .m_tile_index    (m_tile_index),
        .m_draw_priority (m_draw_priority),
        .m_palette_num   (m_palette_num),
        .m_affine_index  (m_affine_index),
        .m_mode_flags    (m_mode_flags),
        .m_box_left      (m_box_left),
        .m_box_right     (m_box_right),
        .m_box_top       (m_box_top),
        .m_box_bottom    (m_box_bottom),
        .m_cell_done     (m_cell_done)
    );

endmodule

`default_nettype wire
